@@ rtl/mrr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response receiver package
// Shared types, register indexes, status and phase codes, and the CRC-16
// byte update used by the response parser.
// ----------------------------------------------------------------------------
package mrr_pkg;

	localparam int MAX_LEN_DEF = 256;

	localparam logic [1:0] REG_SLAVE_ADDRESS   = 2'd0;
	localparam logic [1:0] REG_FUNCTION_CODE   = 2'd1;
	localparam logic [1:0] REG_EXPECTED_LENGTH = 2'd2;

	localparam logic [7:0] SLAVE_ADDRESS_RST   = 8'd1;
	localparam logic [6:0] FUNCTION_CODE_RST   = 7'd3;
	localparam logic [8:0] EXPECTED_LENGTH_RST = 9'd0;

	localparam logic [2:0] ST_WAIT  = 3'd0;
	localparam logic [2:0] ST_OK    = 3'd1;
	localparam logic [2:0] ST_SLAVE = 3'd2;
	localparam logic [2:0] ST_FUNC  = 3'd3;
	localparam logic [2:0] ST_CRC   = 3'd4;
	localparam logic [2:0] ST_LEN   = 3'd5;

	localparam logic [1:0] PH_ADDR = 2'd0;
	localparam logic [1:0] PH_FUNC = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;

	localparam logic [7:0]  FC_SLAVE_ID      = 8'h11;
	localparam logic [8:0]  EXCEPTION_LENGTH = 9'd5;
	localparam logic [8:0]  SLAVE_ID_EXTRA   = 9'd4;
	localparam logic [8:0]  COUNT_MAX        = 9'd511;
	localparam logic [8:0]  SLAVE_ID_POS     = 9'd2;
	localparam logic [15:0] CRC_INIT         = 16'hFFFF;
	localparam logic [15:0] CRC_POLY         = 16'hA001;

	typedef struct packed {
		logic [7:0] slave_address;
		logic [6:0] function_code;
		logic [8:0] expected_length;
	} cfg_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [8:0] byte_count;
	} result_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/mrr_stream_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response receiver stream interfaces
// Valid/ready channels for received bytes and for per-byte results.
// ----------------------------------------------------------------------------
interface mrr_item_if;
	import mrr_pkg::*;
	logic  valid;
	logic  ready;
	item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface mrr_result_if;
	import mrr_pkg::*;
	logic    valid;
	logic    ready;
	result_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ rtl/modbus_rtu_response_receiver_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response receiver
// A byte is registered in the input stage, then its result in the result register.
// Throughput: one byte per cycle when results are taken; the frame state is updated in a single pass.
// The result register lets a new byte enter while a result waits to be taken.
// Reset clears the frame state and loads the register reset values.
// ----------------------------------------------------------------------------
module modbus_rtu_response_receiver_top import mrr_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mrr_item_if.sink   rx,
	mrr_result_if.source res,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [8:0] cfg_wdata
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t res_data_q;
	logic    res_valid_q;
	logic    advance;

	mrr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mrr_parser #(.MAX_LEN(MAX_LEN)) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	assign advance  = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1 <= rx.payload;
		end
		if (advance) begin
			res_data_q <= result;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_data_q;

	// A stalled input side means both stages are occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (valid_s1 && res_valid_q && !res.ready))
		else $error("input stalled while a stage is free");

	// Status codes beyond the length error are never produced.
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.payload.status <= ST_LEN))
		else $error("undefined status code");

	// A complete frame needs at least address, function and one more byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.payload.status == ST_OK || res.payload.status == ST_CRC))
		|-> (res.payload.byte_count >= 9'd3))
		else $error("frame completed too early");

	// A held result keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (res.valid && $stable(res_data_q)))
		else $error("held result changed");

endmodule

@@ rtl/mrr_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the queried slave address, function code and expected length.
// ----------------------------------------------------------------------------
module mrr_cfg_regs import mrr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [8:0] cfg_wdata,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address   <= SLAVE_ADDRESS_RST;
			cfg_q.function_code   <= FUNCTION_CODE_RST;
			cfg_q.expected_length <= EXPECTED_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SLAVE_ADDRESS:   cfg_q.slave_address   <= cfg_wdata[7:0];
				REG_FUNCTION_CODE:   cfg_q.function_code   <= cfg_wdata[6:0];
				REG_EXPECTED_LENGTH: cfg_q.expected_length <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/mrr_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response parser
// Frame state and single-pass evaluation of one byte: address and function
// checks, length tracking and the running CRC residue.
// ----------------------------------------------------------------------------
module mrr_parser import mrr_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    step,
	input  item_t   item,
	output result_t result
);

	localparam logic [10:0] MaxLenW = 11'(MAX_LEN);

	logic [8:0]  count_q;
	logic [1:0]  phase_q;
	logic [15:0] crc_q;
	logic [8:0]  target_q;
	logic [7:0]  rfunc_q;

	logic [8:0]  cnt_eff, cnt_inc, cnt_nxt;
	logic [1:0]  phase_eff, phase_nxt;
	logic [15:0] crc_eff, crc_new, crc_nxt;
	logic [8:0]  tgt_eff, tgt_nxt, tgt_data;
	logic [7:0]  rfunc_nxt;
	logic [2:0]  status;
	logic        begin_frame;
	logic        len_err;
	logic [7:0]  b;

	always_comb begin
		b           = item.rx_byte;
		cnt_eff     = item.frame_start ? 9'd0 : count_q;
		begin_frame = (cnt_eff == 9'd0);
		phase_eff   = begin_frame ? PH_ADDR : phase_q;
		crc_eff     = begin_frame ? CRC_INIT : crc_q;
		tgt_eff     = begin_frame ? cfg.expected_length : target_q;
		len_err     = ({2'b00, cnt_eff} > MaxLenW) || ({2'b00, tgt_eff} > MaxLenW);
		cnt_inc     = (cnt_eff != COUNT_MAX) ? cnt_eff + 9'd1 : cnt_eff;
		crc_new     = crc_byte(crc_eff, b);
		tgt_data    = ((rfunc_q == FC_SLAVE_ID) && (cnt_eff == SLAVE_ID_POS)) ?
			({1'b0, b} + SLAVE_ID_EXTRA) : tgt_eff;

		cnt_nxt   = cnt_eff;
		phase_nxt = phase_eff;
		crc_nxt   = crc_eff;
		tgt_nxt   = tgt_eff;
		rfunc_nxt = rfunc_q;
		status    = ST_WAIT;

		if (len_err) begin
			status = ST_LEN;
		end else begin
			cnt_nxt = cnt_inc;
			crc_nxt = crc_new;
			unique case (phase_eff)
				PH_ADDR: begin
					phase_nxt = PH_FUNC;
					status    = (b != cfg.slave_address) ? ST_SLAVE : ST_WAIT;
				end
				PH_FUNC: begin
					phase_nxt = PH_DATA;
					rfunc_nxt = b;
					if (b != {1'b0, cfg.function_code}) begin
						tgt_nxt = EXCEPTION_LENGTH;
						if (b != {1'b1, cfg.function_code}) begin
							status = ST_FUNC;
						end
					end
				end
				default: begin
					tgt_nxt = tgt_data;
					if (tgt_data != cnt_inc) begin
						status = ST_WAIT;
					end else begin
						status = (crc_new == 16'h0000) ? ST_OK : ST_CRC;
					end
				end
			endcase
		end

		result.status     = status;
		result.byte_count = cnt_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 9'd0;
			phase_q  <= PH_ADDR;
			crc_q    <= CRC_INIT;
			target_q <= EXPECTED_LENGTH_RST;
			rfunc_q  <= 8'h00;
		end else if (step) begin
			count_q  <= cnt_nxt;
			phase_q  <= phase_nxt;
			crc_q    <= crc_nxt;
			target_q <= tgt_nxt;
			rfunc_q  <= rfunc_nxt;
		end
	end

endmodule

@@ tb/sv/mrr_reply_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response receiver reply checker
// Watches the byte channel, the reply channel and the register port. Each
// accepted byte is run through a local model of the response parser, and the
// reply it should cause is queued. Each accepted reply is compared with the
// oldest queued one. Mismatches and the number of outstanding replies are
// handed to the testbench top.
// ----------------------------------------------------------------------------
module mrr_reply_checker import mrr_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	input  logic       rx_ready,
	input  item_t      rx_payload,
	input  logic       res_valid,
	input  logic       res_ready,
	input  result_t    res_payload,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [8:0] cfg_wdata,
	output int         mismatch_count,
	output int         pending_results
);

	logic [7:0]  slave_addr;
	logic [6:0]  func_code;
	logic [8:0]  length_reg;
	logic [8:0]  bytes_in_frame;
	logic [1:0]  parse_step;
	logic [15:0] running_crc;
	logic [8:0]  frame_target;
	logic [7:0]  func_received;
	result_t     expected_replies[$];

	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	task automatic predict_reply(input item_t it, output result_t r);
		logic [8:0] pos;
		r.status = ST_WAIT;
		if (it.frame_start) begin
			bytes_in_frame = '0;
		end
		if (bytes_in_frame == '0) begin
			parse_step   = PH_ADDR;
			running_crc  = CRC_INIT;
			frame_target = length_reg;
		end
		if (bytes_in_frame > MAX_LEN || frame_target > MAX_LEN) begin
			r.status = ST_LEN;
		end else begin
			pos = bytes_in_frame;
			if (bytes_in_frame != COUNT_MAX) begin
				bytes_in_frame++;
			end
			running_crc = crc16_update(running_crc, it.rx_byte);
			case (parse_step)
				PH_ADDR: begin
					parse_step = PH_FUNC;
					if (it.rx_byte != slave_addr) begin
						r.status = ST_SLAVE;
					end
				end
				PH_FUNC: begin
					parse_step    = PH_DATA;
					func_received = it.rx_byte;
					if (it.rx_byte != {1'b0, func_code}) begin
						frame_target = EXCEPTION_LENGTH;
						if (it.rx_byte != {1'b1, func_code}) begin
							r.status = ST_FUNC;
						end
					end
				end
				default: begin
					if (func_received == FC_SLAVE_ID && pos == SLAVE_ID_POS) begin
						frame_target = {1'b0, it.rx_byte} + SLAVE_ID_EXTRA;
					end
					if (frame_target == bytes_in_frame) begin
						r.status = (running_crc == '0) ? ST_OK : ST_CRC;
					end
				end
			endcase
		end
		r.byte_count = bytes_in_frame;
	endtask

	task automatic report_reply(input string what, input result_t want, input result_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t ns: %s: expected status %0d count %0d, got status %0d count %0d",
				$time, what, want.status, want.byte_count, got.status, got.byte_count);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			slave_addr      = SLAVE_ADDRESS_RST;
			func_code       = FUNCTION_CODE_RST;
			length_reg      = EXPECTED_LENGTH_RST;
			bytes_in_frame  = '0;
			parse_step      = PH_ADDR;
			running_crc     = CRC_INIT;
			frame_target    = EXPECTED_LENGTH_RST;
			func_received   = '0;
			expected_replies.delete();
			mismatch_count  = 0;
			pending_results = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_SLAVE_ADDRESS:   slave_addr = cfg_wdata[7:0];
					REG_FUNCTION_CODE:   func_code  = cfg_wdata[6:0];
					REG_EXPECTED_LENGTH: length_reg = cfg_wdata;
					default: ;
				endcase
			end
			if (res_valid && res_ready) begin
				if (expected_replies.size() == 0) begin
					report_reply("reply with no transaction outstanding", '0, res_payload);
				end else begin
					want = expected_replies.pop_front();
					if (res_payload.status !== want.status ||
						res_payload.byte_count !== want.byte_count) begin
						report_reply("reply mismatch", want, res_payload);
					end
				end
			end
			if (rx_valid && rx_ready) begin
				predict_reply(rx_payload, want);
				expected_replies.push_back(want);
			end
			pending_results = expected_replies.size();
		end
	end

endmodule

@@ tb/sv/tb_modbus_rtu_response_receiver_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response receiver testbench
// Drives response frames into the receiver: a short directed set covering the
// register extremes, exception and report-slave-id replies and the slave and
// function error statuses, then random settings with mostly well-formed frames,
// corrupted and truncated frames, a long overrun and noise. Both channels idle
// at random. The reply checker predicts and compares every status.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_response_receiver_top;
	import mrr_pkg::*;

	localparam int MAX_LEN = MAX_LEN_DEF;

	typedef logic [7:0] octet_q_t[$];

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_idx;
	logic [8:0] cfg_wdata;
	int         mismatches;
	int         pending_results;
	bit         idle_on;
	int         bytes_sent;
	int         frames_sent;
	int         settings_used;
	logic [7:0] cur_slave;
	logic [6:0] cur_func;
	logic [8:0] cur_len;

	mrr_item_if   rx_if();
	mrr_result_if res_if();

	modbus_rtu_response_receiver_top #(
		.MAX_LEN(MAX_LEN)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx_if),
		.res      (res_if),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	mrr_reply_checker #(
		.MAX_LEN(MAX_LEN)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_if.valid),
		.rx_ready       (rx_if.ready),
		.rx_payload     (rx_if.payload),
		.res_valid      (res_if.valid),
		.res_ready      (res_if.ready),
		.res_payload    (res_if.payload),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatches),
		.pending_results(pending_results)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#10_000_000;
		$display("Run timed out with %0d replies outstanding.", pending_results);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int stall;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = idle_on ? $urandom_range(10, 0) : 0;
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	function automatic logic [7:0] rand_octet();
		return 8'($urandom_range(255, 0));
	endfunction

	function automatic octet_q_t with_crc(input octet_q_t f);
		logic [15:0] c;
		c = CRC_INIT;
		foreach (f[i]) begin
			c = c ^ {8'h00, f[i]};
			for (int k = 0; k < 8; k++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
		end
		f.push_back(c[7:0]);
		f.push_back(c[15:8]);
		return f;
	endfunction

	function automatic octet_q_t good_frame();
		octet_q_t f;
		int       n;
		f.push_back(cur_slave);
		f.push_back({1'b0, cur_func});
		if (cur_func == FC_SLAVE_ID[6:0]) begin
			n = ($urandom_range(9, 0) == 0) ? $urandom_range(255, 0) : $urandom_range(12, 0);
			f.push_back(8'(n));
			for (int k = 1; k < n; k++) begin
				f.push_back(rand_octet());
			end
		end else begin
			n = (cur_len >= 4 && cur_len <= MAX_LEN) ? int'(cur_len) - 4 : $urandom_range(6, 0);
			for (int k = 0; k < n; k++) begin
				f.push_back(rand_octet());
			end
		end
		return with_crc(f);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic start);
		item_t it;
		int    gap;
		it.rx_byte     = b;
		it.frame_start = start;
		gap = idle_on ? $urandom_range(10, 0) : 0;
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.payload <= it;
		do @(posedge clk); while (!rx_if.ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(input octet_q_t f);
		foreach (f[i]) begin
			send_byte(f[i], i == 0);
		end
		frames_sent++;
	endtask

	task automatic wait_for_results();
		rx_if.valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_settings(input logic [7:0] sa, input logic [6:0] fc, input logic [8:0] len);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_SLAVE_ADDRESS;
		cfg_wdata <= {1'b0, sa};
		@(negedge clk);
		cfg_idx   <= REG_FUNCTION_CODE;
		cfg_wdata <= {2'b00, fc};
		@(negedge clk);
		cfg_idx   <= REG_EXPECTED_LENGTH;
		cfg_wdata <= len;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_slave = sa;
		cur_func  = fc;
		cur_len   = len;
		settings_used++;
	endtask

	task automatic pick_settings();
		int          r;
		logic [7:0]  sa;
		logic [6:0]  fc;
		logic [8:0]  len;
		r  = $urandom_range(9, 0);
		sa = (r == 0) ? 8'd0 : (r == 1) ? 8'd247 : 8'($urandom_range(247, 0));
		r  = $urandom_range(9, 0);
		fc = (r < 3) ? FC_SLAVE_ID[6:0] : (r == 3) ? 7'd0 : (r == 4) ? 7'd127 :
			7'($urandom_range(127, 0));
		r  = $urandom_range(99, 0);
		len = (r < 75) ? 9'($urandom_range(24, 4)) : (r < 85) ? 9'($urandom_range(3, 0)) :
			(r < 90) ? 9'd511 : (r < 96) ? 9'($urandom_range(510, 257)) :
			9'($urandom_range(MAX_LEN, 200));
		load_settings(sa, fc, len);
	endtask

	task automatic send_random_frame();
		octet_q_t f;
		int       kind;
		int       idx;
		int       n;
		kind = $urandom_range(99, 0);
		if (kind >= 90) begin
			n = $urandom_range(8, 1);
			repeat (n) send_byte(rand_octet(), 1'($urandom_range(1, 0)));
		end else begin
			f = good_frame();
			if (kind >= 80) begin
				n = $urandom_range(f.size() - 1, 1);
				while (f.size() > n) void'(f.pop_back());
			end else if (kind >= 70) begin
				idx = $urandom_range(f.size() - 1, 0);
				f[idx] = f[idx] ^ (8'd1 << $urandom_range(7, 0));
			end else if (kind >= 60) begin
				f.delete();
				f.push_back(cur_slave);
				f.push_back({1'b1, cur_func});
				f.push_back(rand_octet());
				f = with_crc(f);
			end
			send_frame(f);
		end
	endtask

	task automatic send_overrun();
		send_byte(cur_slave, 1'b1);
		send_byte({1'b0, cur_func}, 1'b0);
		repeat (MAX_LEN + 2) send_byte(rand_octet(), 1'b0);
		frames_sent++;
	endtask

	initial begin
		octet_q_t frame;
		int       phase_no;
		int       stop_at;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_idx        = REG_SLAVE_ADDRESS;
		cfg_wdata      = '0;
		rx_if.valid    = 1'b0;
		rx_if.payload  = '0;
		idle_on        = 1'b0;
		bytes_sent     = 0;
		frames_sent    = 0;
		settings_used  = 0;
		cur_slave      = SLAVE_ADDRESS_RST;
		cur_func       = FUNCTION_CODE_RST;
		cur_len        = EXPECTED_LENGTH_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		load_settings(8'd247, 7'd127, 9'd8);
		frame = {8'd247, 8'd127, 8'h00, 8'hFF, 8'h80, 8'h7F};
		frame = with_crc(frame);
		send_frame(frame);
		frame = {8'd247, 8'hFF, 8'h02};
		frame = with_crc(frame);
		send_frame(frame);
		frame = {8'h00, 8'h00, 8'h55, 8'hAA, 8'h12};
		send_frame(frame);
		frame = {8'd247, 8'd127};
		send_frame(frame);
		wait_for_results();
		load_settings(8'd1, FC_SLAVE_ID[6:0], 9'd0);
		frame = {8'd1, FC_SLAVE_ID, 8'h01};
		frame = with_crc(frame);
		send_frame(frame);
		wait_for_results();

		phase_no = 0;
		while (bytes_sent < 1600) begin
			idle_on = ($urandom_range(3, 0) != 0);
			if (phase_no == 0) begin
				load_settings(8'($urandom_range(247, 0)), 7'd0, 9'(MAX_LEN));
				frame = good_frame();
				send_frame(frame);
			end else if (phase_no == 1) begin
				load_settings(8'd247, 7'd3, 9'd0);
				send_overrun();
			end else begin
				pick_settings();
				stop_at = bytes_sent + $urandom_range(80, 30);
				while (bytes_sent < stop_at) send_random_frame();
			end
			wait_for_results();
			phase_no++;
		end

		$display("Run drove %0d bytes in %0d frames over %0d register settings, with random gaps.",
			bytes_sent, frames_sent, settings_used);
		$display("Mismatches counted: %0d.", mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
